// File: rtl/mfvn_pkg.sv
// shared types, widths and codes of the mesh face vertex normal unit
`default_nettype none

package mfvn_pkg;

    localparam int VERTEX_DEPTH_DEF = 1024;
    localparam int ADDR_XW  = 17;
    localparam int IDX_W    = 10;
    localparam int POS_W    = 24;
    localparam int EDGE_W   = 25;
    localparam int ACC_W    = 32;
    localparam int TAG_W    = 16;
    localparam int NRM_W    = 16;
    localparam int NRM_FRAC = 15;
    localparam int MAG_W    = 51;
    localparam int SHF_LIM  = 30;
    localparam int MUL_W    = 32;
    localparam int SQ_W     = 62;
    localparam int ROOT_W   = 64;
    localparam int LEN_W    = 31;
    localparam int QUO_W    = 17;
    localparam int NUM_W    = 46;
    localparam int CNT_W    = 5;

    localparam int CROSS_STEPS = 6;
    localparam int SQ_STEPS    = 3;
    localparam int DIV_STEPS   = QUO_W;
    localparam int ADD_STEPS   = 6;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_FACE  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ASEL_A = 2'd0,
        ASEL_B = 2'd1,
        ASEL_C = 2'd2,
        ASEL_V = 2'd3
    } t_asel;

    typedef logic [3:0] t_msel;
    localparam t_msel MS_YZ  = 4'd0;
    localparam t_msel MS_ZY  = 4'd1;
    localparam t_msel MS_ZX  = 4'd2;
    localparam t_msel MS_XZ  = 4'd3;
    localparam t_msel MS_XY  = 4'd4;
    localparam t_msel MS_YX  = 4'd5;
    localparam t_msel MS_SQ0 = 4'd6;
    localparam t_msel MS_SQ1 = 4'd7;
    localparam t_msel MS_SQ2 = 4'd8;

    localparam logic [1:0] LAST_COMP = 2'd2;

    typedef struct packed {
        logic  load;
        logic  store_wr;
        t_asel st_rd_sel;
        logic  cap_a;
        logic  cap_e1;
        logic  cap_e2;
        logic  mul_en;
        t_msel mul_sel;
        logic  acc_en;
        t_msel acc_sel;
        t_asel acc_rd_sel;
        logic  acc_wr;
        logic  load_acc;
        logic  set_degen;
        logic  shift;
        logic  sum_clr;
        logic  sqrt_init;
        logic  sqrt_step;
        logic  div_init;
        logic  div_step;
        logic  div_store;
        logic [1:0] k;
        logic  clr_step;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic zero;
        logic big;
        logic sqrt_done;
        logic clr_last;
    } t_stat;

endpackage

`default_nettype wire

// File: rtl/mesh_face_vertex_normals.sv
// top level of the mesh face vertex normal unit
//
//  channel  direction  handshake                  payload
//  in       input      i_in_valid / o_in_ready    kind, index, position, corners, face tag
//  out      output     o_out_valid / i_out_ready  item tag, normal x y z, degenerate
//  cfg      input      i_cfg_valid / o_cfg_ready  vertex normals enable
//
// a write item stores its position; a face reads its corners and forms the cross product;
// a face or read vector that is not zero is shifted, its square root taken and three divisions
// run on the shared datapath, and a face with enable set then adds into its corners' sums
// clear item and reset each sweep every word of the accumulator memory before idle
// one item in flight; the next item is taken while the last result waits in its register
// a stalled output holds the finished item in the final state until the register frees
`default_nettype none

module mesh_face_vertex_normals import mfvn_pkg::*; #(
    parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [1:0]              i_kind,
    input  wire logic [IDX_W-1:0]        i_vertex_index,
    input  wire logic signed [POS_W-1:0] i_pos_x,
    input  wire logic signed [POS_W-1:0] i_pos_y,
    input  wire logic signed [POS_W-1:0] i_pos_z,
    input  wire logic [IDX_W-1:0]        i_corner_a,
    input  wire logic [IDX_W-1:0]        i_corner_b,
    input  wire logic [IDX_W-1:0]        i_corner_c,
    input  wire logic [TAG_W-1:0]        i_face_tag,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [TAG_W-1:0]             o_item_tag,
    output logic signed [NRM_W-1:0]      o_norm_x,
    output logic signed [NRM_W-1:0]      o_norm_y,
    output logic signed [NRM_W-1:0]      o_norm_z,
    output logic                         o_degenerate,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic                    i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    mfvn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    mfvn_dp #(
        .VERTEX_DEPTH (VERTEX_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_kind         (i_kind),
        .i_vertex_index (i_vertex_index),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_corner_a     (i_corner_a),
        .i_corner_b     (i_corner_b),
        .i_corner_c     (i_corner_c),
        .i_face_tag     (i_face_tag),
        .o_item_tag     (o_item_tag),
        .o_norm_x       (o_norm_x),
        .o_norm_y       (o_norm_y),
        .o_norm_z       (o_norm_z),
        .o_degenerate   (o_degenerate)
    );

endmodule

`default_nettype wire

// File: rtl/mfvn_dp.sv
// datapath: position and accumulator memories, multiplier, square root and divider
`default_nettype none

module mfvn_dp import mfvn_pkg::*; #(
    parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cmd                    i_cmd,
    output t_stat                        o_stat,
    input  wire logic [1:0]              i_kind,
    input  wire logic [IDX_W-1:0]        i_vertex_index,
    input  wire logic signed [POS_W-1:0] i_pos_x,
    input  wire logic signed [POS_W-1:0] i_pos_y,
    input  wire logic signed [POS_W-1:0] i_pos_z,
    input  wire logic [IDX_W-1:0]        i_corner_a,
    input  wire logic [IDX_W-1:0]        i_corner_b,
    input  wire logic [IDX_W-1:0]        i_corner_c,
    input  wire logic [TAG_W-1:0]        i_face_tag,
    output logic [TAG_W-1:0]             o_item_tag,
    output logic signed [NRM_W-1:0]      o_norm_x,
    output logic signed [NRM_W-1:0]      o_norm_y,
    output logic signed [NRM_W-1:0]      o_norm_z,
    output logic                         o_degenerate
);

    localparam int AW = $clog2(VERTEX_DEPTH);
    localparam logic [NRM_W-2:0] NRM_MAX = '1;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_pos;

    typedef struct packed {
        logic signed [ACC_W-1:0] x;
        logic signed [ACC_W-1:0] y;
        logic signed [ACC_W-1:0] z;
    } t_acc;

    function automatic logic in_rng(input logic [IDX_W-1:0] idx);
        return ADDR_XW'(idx) < ADDR_XW'(VERTEX_DEPTH);
    endfunction

    function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [ADDR_XW-1:0] w;
        w = ADDR_XW'(idx);
        return w[AW-1:0];
    endfunction

    function automatic logic [MAG_W-1:0] abs_m(input logic signed [MAG_W-1:0] v);
        return v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [NRM_W-1:0] b);
        logic signed [ACC_W:0] s;
        s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s[ACC_W-1:0];
    endfunction

    // captured item
    t_kind                   r_kind;
    logic [IDX_W-1:0]        r_vidx;
    t_pos                    r_pos;
    logic [IDX_W-1:0]        r_ca;
    logic [IDX_W-1:0]        r_cb;
    logic [IDX_W-1:0]        r_cc;
    logic [TAG_W-1:0]        r_tag;

    // memories
    t_pos                    r_st_mem [VERTEX_DEPTH];
    t_pos                    r_st_rd;
    logic                    r_st_ok;
    t_acc                    r_acc_mem [VERTEX_DEPTH];
    t_acc                    r_acc_rd;
    logic                    r_acc_ok;
    logic [AW-1:0]           r_clr_addr;

    // arithmetic
    t_pos                    r_pa;
    logic signed [EDGE_W-1:0] r_e1 [3];
    logic signed [EDGE_W-1:0] r_e2 [3];
    logic signed [2*MUL_W-1:0] r_prod;
    logic signed [MAG_W-1:0] r_tmp;
    logic [MAG_W-1:0]        r_mag [3];
    logic                    r_sgn [3];
    logic [SQ_W-1:0]         r_sum;
    logic [ROOT_W-1:0]       r_srem;
    logic [ROOT_W-1:0]       r_root;
    logic [ROOT_W-1:0]       r_bit;
    logic [LEN_W-1:0]        r_drem;
    logic [QUO_W-1:0]        r_dnum;
    logic [QUO_W-1:0]        r_quo;
    logic signed [NRM_W-1:0] r_n [3];
    logic                    r_degen;

    logic [IDX_W-1:0]        st_idx;
    logic [IDX_W-1:0]        acc_idx;
    t_pos                    pos;
    t_acc                    accv;
    logic signed [MUL_W-1:0] mul_a;
    logic signed [MUL_W-1:0] mul_b;
    logic signed [MAG_W-1:0] diff;
    logic [ROOT_W-1:0]       sq_t;
    logic [LEN_W-1:0]        len;
    logic [NUM_W-1:0]        num;
    logic [LEN_W:0]          rem2;
    logic                    q_ge;
    logic [LEN_W:0]          rem_sub;
    logic [NRM_W-2:0]        q_sat;
    logic signed [NRM_W-1:0] q_pos;
    t_acc                    acc_sum;

    always_comb begin
        case (i_cmd.st_rd_sel)
            ASEL_A:  st_idx = r_ca;
            ASEL_B:  st_idx = r_cb;
            ASEL_C:  st_idx = r_cc;
            default: st_idx = r_vidx;
        endcase
        case (i_cmd.acc_rd_sel)
            ASEL_A:  acc_idx = r_ca;
            ASEL_B:  acc_idx = r_cb;
            ASEL_C:  acc_idx = r_cc;
            default: acc_idx = r_vidx;
        endcase
    end

    assign pos  = r_st_ok ? r_st_rd : '0;
    assign accv = r_acc_ok ? r_acc_rd : '0;

    always_comb begin
        case (i_cmd.mul_sel)
            MS_YZ: begin mul_a = MUL_W'(r_e1[1]); mul_b = MUL_W'(r_e2[2]); end
            MS_ZY: begin mul_a = MUL_W'(r_e1[2]); mul_b = MUL_W'(r_e2[1]); end
            MS_ZX: begin mul_a = MUL_W'(r_e1[2]); mul_b = MUL_W'(r_e2[0]); end
            MS_XZ: begin mul_a = MUL_W'(r_e1[0]); mul_b = MUL_W'(r_e2[2]); end
            MS_XY: begin mul_a = MUL_W'(r_e1[0]); mul_b = MUL_W'(r_e2[1]); end
            MS_YX: begin mul_a = MUL_W'(r_e1[1]); mul_b = MUL_W'(r_e2[0]); end
            MS_SQ0: begin
                mul_a = {2'b00, r_mag[0][SHF_LIM-1:0]};
                mul_b = {2'b00, r_mag[0][SHF_LIM-1:0]};
            end
            MS_SQ1: begin
                mul_a = {2'b00, r_mag[1][SHF_LIM-1:0]};
                mul_b = {2'b00, r_mag[1][SHF_LIM-1:0]};
            end
            MS_SQ2: begin
                mul_a = {2'b00, r_mag[2][SHF_LIM-1:0]};
                mul_b = {2'b00, r_mag[2][SHF_LIM-1:0]};
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign diff    = r_tmp - $signed(r_prod[MAG_W-1:0]);
    assign sq_t    = r_root + r_bit;
    assign len     = r_root[LEN_W-1:0];
    assign num     = {1'b0, r_mag[i_cmd.k][SHF_LIM-1:0], {NRM_FRAC{1'b0}}}
                     + NUM_W'(len[LEN_W-1:1]);
    assign rem2    = {r_drem, r_dnum[QUO_W-1]};
    assign q_ge    = rem2 >= {1'b0, len};
    assign rem_sub = rem2 - {1'b0, len};
    assign q_sat   = (r_quo > {2'b00, NRM_MAX}) ? NRM_MAX : r_quo[NRM_W-2:0];
    assign q_pos   = {1'b0, q_sat};

    assign acc_sum.x = sat_add(r_acc_rd.x, r_n[0]);
    assign acc_sum.y = sat_add(r_acc_rd.y, r_n[1]);
    assign acc_sum.z = sat_add(r_acc_rd.z, r_n[2]);

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_wr && in_rng(r_vidx)) begin
            r_st_mem[to_addr(r_vidx)] <= r_pos;
        end
        r_st_rd <= r_st_mem[to_addr(st_idx)];
        r_st_ok <= in_rng(st_idx);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_acc_mem[r_clr_addr] <= '0;
        end else if (i_cmd.acc_wr && in_rng(acc_idx)) begin
            r_acc_mem[to_addr(acc_idx)] <= acc_sum;
        end
        r_acc_rd <= r_acc_mem[to_addr(acc_idx)];
        r_acc_ok <= in_rng(acc_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= o_stat.clr_last ? '0 : r_clr_addr + 1'b1;
        end
    end

    // item capture, edges, multiplier
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= t_kind'(i_kind);
            r_vidx <= i_vertex_index;
            r_pos  <= '{i_pos_x, i_pos_y, i_pos_z};
            r_ca   <= i_corner_a;
            r_cb   <= i_corner_b;
            r_cc   <= i_corner_c;
            r_tag  <= i_face_tag;
        end
        if (i_cmd.cap_a) begin
            r_pa <= pos;
        end
        if (i_cmd.cap_e1) begin
            r_e1[0] <= EDGE_W'(pos.x) - EDGE_W'(r_pa.x);
            r_e1[1] <= EDGE_W'(pos.y) - EDGE_W'(r_pa.y);
            r_e1[2] <= EDGE_W'(pos.z) - EDGE_W'(r_pa.z);
        end
        if (i_cmd.cap_e2) begin
            r_e2[0] <= EDGE_W'(pos.x) - EDGE_W'(r_pa.x);
            r_e2[1] <= EDGE_W'(pos.y) - EDGE_W'(r_pa.y);
            r_e2[2] <= EDGE_W'(pos.z) - EDGE_W'(r_pa.z);
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
    end

    // vector magnitudes, sum of squares
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_acc) begin
            r_mag[0] <= abs_m(MAG_W'(accv.x));
            r_mag[1] <= abs_m(MAG_W'(accv.y));
            r_mag[2] <= abs_m(MAG_W'(accv.z));
            r_sgn[0] <= accv.x[ACC_W-1];
            r_sgn[1] <= accv.y[ACC_W-1];
            r_sgn[2] <= accv.z[ACC_W-1];
        end else if (i_cmd.shift) begin
            for (int i = 0; i < 3; i++) begin
                r_mag[i] <= r_mag[i] >> 1;
            end
        end else if (i_cmd.acc_en) begin
            case (i_cmd.acc_sel)
                MS_YZ, MS_ZX, MS_XY: r_tmp <= $signed(r_prod[MAG_W-1:0]);
                MS_ZY: begin r_mag[0] <= abs_m(diff); r_sgn[0] <= diff[MAG_W-1]; end
                MS_XZ: begin r_mag[1] <= abs_m(diff); r_sgn[1] <= diff[MAG_W-1]; end
                MS_YX: begin r_mag[2] <= abs_m(diff); r_sgn[2] <= diff[MAG_W-1]; end
                MS_SQ0, MS_SQ1, MS_SQ2: r_sum <= r_sum + r_prod[SQ_W-1:0];
                default: r_tmp <= r_tmp;
            endcase
        end
        if (i_cmd.sum_clr) begin
            r_sum <= '0;
        end
    end

    // square root, one result bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_init) begin
            r_srem <= ROOT_W'(r_sum);
            r_root <= '0;
            r_bit  <= {2'b01, {SQ_W{1'b0}}};
        end else if (i_cmd.sqrt_step) begin
            if (r_srem >= sq_t) begin
                r_srem <= r_srem - sq_t;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_drem <= LEN_W'(num[NUM_W-1:QUO_W]);
            r_dnum <= num[QUO_W-1:0];
            r_quo  <= '0;
        end else if (i_cmd.div_step) begin
            r_drem <= q_ge ? rem_sub[LEN_W-1:0] : rem2[LEN_W-1:0];
            r_dnum <= r_dnum << 1;
            r_quo  <= {r_quo[QUO_W-2:0], q_ge};
        end
    end

    // normal and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                r_n[i] <= '0;
            end
            r_degen <= 1'b0;
        end else begin
            if (i_cmd.div_store) begin
                r_n[i_cmd.k] <= r_sgn[i_cmd.k] ? -q_pos : q_pos;
            end
            if (i_cmd.set_degen) begin
                r_degen <= 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            case (r_kind)
                KIND_FACE: o_item_tag <= r_tag;
                KIND_READ: o_item_tag <= TAG_W'(r_vidx);
                default:   o_item_tag <= '0;
            endcase
            o_norm_x     <= r_n[0];
            o_norm_y     <= r_n[1];
            o_norm_z     <= r_n[2];
            o_degenerate <= r_degen;
        end
    end

    assign o_stat.zero      = (r_mag[0] | r_mag[1] | r_mag[2]) == '0;
    assign o_stat.big       = |{r_mag[0][MAG_W-1:SHF_LIM], r_mag[1][MAG_W-1:SHF_LIM],
                                r_mag[2][MAG_W-1:SHF_LIM]};
    assign o_stat.sqrt_done = r_bit == '0;
    assign o_stat.clr_last  = r_clr_addr == AW'(VERTEX_DEPTH - 1);

endmodule

`default_nettype wire

// File: rtl/mfvn_ctrl.sv
// controller: sequences each item through the datapath, owns handshakes and enable
`default_nettype none

module mfvn_ctrl import mfvn_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_kind,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_cmd            o_cmd,
    input  wire t_stat      i_stat
);

    typedef enum logic [4:0] {
        S_RCLR, S_IDLE, S_WR, S_RDA, S_RDB, S_RDC, S_E2, S_CROSS, S_RDV, S_RDV2,
        S_CHK, S_SHF, S_SQ, S_SQI, S_SQRT, S_DIVI, S_DIV, S_DIVE, S_ADD, S_CLR, S_FIN
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_k, n_k;
    t_kind            r_kind, n_kind;
    logic             r_en;
    logic             r_out_valid;
    t_cmd             cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_cnt   = r_cnt;
        n_k     = r_k;
        n_kind  = r_kind;
        case (r_state)
            S_RCLR: begin
                cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_kind   = t_kind'(i_kind);
                    case (t_kind'(i_kind))
                        KIND_WRITE: n_state = S_WR;
                        KIND_FACE:  n_state = S_RDA;
                        KIND_READ:  n_state = S_RDV;
                        default:    n_state = S_CLR;
                    endcase
                end
            end
            S_WR: begin
                cmd.store_wr = 1'b1;
                n_state      = S_FIN;
            end
            S_RDA: begin
                cmd.st_rd_sel = ASEL_A;
                n_state       = S_RDB;
            end
            S_RDB: begin
                cmd.st_rd_sel = ASEL_B;
                cmd.cap_a     = 1'b1;
                n_state       = S_RDC;
            end
            S_RDC: begin
                cmd.st_rd_sel = ASEL_C;
                cmd.cap_e1    = 1'b1;
                n_state       = S_E2;
            end
            S_E2: begin
                cmd.cap_e2 = 1'b1;
                n_cnt      = '0;
                n_state    = S_CROSS;
            end
            S_CROSS: begin
                cmd.mul_en  = r_cnt < CNT_W'(CROSS_STEPS);
                cmd.mul_sel = MS_YZ + t_msel'(r_cnt);
                cmd.acc_en  = r_cnt != '0;
                cmd.acc_sel = t_msel'(MS_YZ + t_msel'(r_cnt) - 1'b1);
                if (r_cnt == CNT_W'(CROSS_STEPS)) n_state = S_CHK;
                else n_cnt = r_cnt + 1'b1;
            end
            S_RDV: begin
                cmd.acc_rd_sel = ASEL_V;
                n_state        = S_RDV2;
            end
            S_RDV2: begin
                cmd.load_acc = 1'b1;
                n_state      = S_CHK;
            end
            S_CHK: begin
                if (i_stat.zero) begin
                    cmd.set_degen = 1'b1;
                    n_state       = S_FIN;
                end else begin
                    n_state = S_SHF;
                end
            end
            S_SHF: begin
                if (i_stat.big) begin
                    cmd.shift = 1'b1;
                end else begin
                    cmd.sum_clr = 1'b1;
                    n_cnt       = '0;
                    n_state     = S_SQ;
                end
            end
            S_SQ: begin
                cmd.mul_en  = r_cnt < CNT_W'(SQ_STEPS);
                cmd.mul_sel = MS_SQ0 + t_msel'(r_cnt);
                cmd.acc_en  = r_cnt != '0;
                cmd.acc_sel = t_msel'(MS_SQ0 + t_msel'(r_cnt) - 1'b1);
                if (r_cnt == CNT_W'(SQ_STEPS)) n_state = S_SQI;
                else n_cnt = r_cnt + 1'b1;
            end
            S_SQI: begin
                cmd.sqrt_init = 1'b1;
                n_state       = S_SQRT;
            end
            S_SQRT: begin
                if (i_stat.sqrt_done) begin
                    n_k     = '0;
                    n_state = S_DIVI;
                end else begin
                    cmd.sqrt_step = 1'b1;
                end
            end
            S_DIVI: begin
                cmd.k        = r_k;
                cmd.div_init = 1'b1;
                n_cnt        = '0;
                n_state      = S_DIV;
            end
            S_DIV: begin
                cmd.k        = r_k;
                cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = S_DIVE;
                else n_cnt = r_cnt + 1'b1;
            end
            S_DIVE: begin
                cmd.k         = r_k;
                cmd.div_store = 1'b1;
                if (r_k == LAST_COMP) begin
                    n_cnt   = '0;
                    n_state = (r_kind == KIND_FACE && r_en) ? S_ADD : S_FIN;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_DIVI;
                end
            end
            S_ADD: begin
                cmd.acc_rd_sel = t_asel'(r_cnt[2:1]);
                cmd.acc_wr     = r_cnt[0];
                if (r_cnt == CNT_W'(ADD_STEPS - 1)) n_state = S_FIN;
                else n_cnt = r_cnt + 1'b1;
            end
            S_CLR: begin
                cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RCLR;
            r_cnt       <= '0;
            r_k         <= '0;
            r_kind      <= KIND_WRITE;
            r_en        <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
            r_kind  <= n_kind;
            if (i_cfg_valid) begin
                r_en <= i_cfg_data;
            end
            if (cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CNT_W'(DIV_STEPS))
        else $error("step counter out of range");
    a_comp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= LAST_COMP)
        else $error("component index out of range");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while held");
    a_sqrt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> !i_stat.zero)
        else $error("normalizing a zero vector");
`endif

endmodule

`default_nettype wire

// File: tb/tb_mesh_face_vertex_normals.sv
// self-checking testbench of the mesh face vertex normal unit
`default_nettype none

module tb_mesh_face_vertex_normals;
    import mfvn_pkg::*;

    typedef struct {
        t_kind                    kind;
        logic [IDX_W-1:0]         vidx;
        logic signed [POS_W-1:0]  px, py, pz;
        logic [IDX_W-1:0]         ca, cb, cc;
        logic [TAG_W-1:0]         tag;
    } t_mesh_item;

    typedef struct {
        logic [TAG_W-1:0]         tag;
        logic signed [NRM_W-1:0]  nx, ny, nz;
        logic                     degen;
    } t_normal_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [1:0] i_kind = '0;
    logic [IDX_W-1:0] i_vertex_index = '0;
    logic signed [POS_W-1:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic [IDX_W-1:0] i_corner_a = '0, i_corner_b = '0, i_corner_c = '0;
    logic [TAG_W-1:0] i_face_tag = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [TAG_W-1:0] o_item_tag;
    logic signed [NRM_W-1:0] o_norm_x, o_norm_y, o_norm_z;
    logic o_degenerate;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic i_cfg_data = 1'b0;

    mesh_face_vertex_normals dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_mesh_item  pending_items[$];
    t_normal_res expected_normals[$];
    int          errors = 0;
    int          idle_mode = 0;
    logic        hold_sender = 1'b0;

    // predictor state
    logic signed [POS_W-1:0] pos_x_mem[1024], pos_y_mem[1024], pos_z_mem[1024];
    logic signed [ACC_W-1:0] sum_x_mem[1024], sum_y_mem[1024], sum_z_mem[1024];
    logic                    enable_q = 1'b1;

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic void unit_normal(input longint vx, vy, vz,
                                        output logic signed [NRM_W-1:0] nx, ny, nz,
                                        output logic dg);
        longint v[3];
        longint unsigned m[3];
        longint unsigned mx, sum, len, q;
        logic signed [NRM_W-1:0] n[3];
        v = '{vx, vy, vz};
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
            if (m[i] > mx) mx = m[i];
        end
        n = '{16'sd0, 16'sd0, 16'sd0};
        dg = (mx == 0);
        if (!dg) begin
            while (mx >= (64'd1 << SHF_LIM)) begin
                mx = mx >> 1;
                for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            end
            sum = 0;
            for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
            len = int_sqrt(sum);
            for (int i = 0; i < 3; i++) begin
                q = ((m[i] << NRM_FRAC) + (len >> 1)) / len;
                if (q > 32767) q = 32767;
                n[i] = v[i] < 0 ? -16'(q) : 16'(q);
            end
        end
        nx = n[0]; ny = n[1]; nz = n[2];
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_sum(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [NRM_W-1:0] b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s[ACC_W-1:0];
    endfunction

    function automatic t_normal_res predict_normal(input t_mesh_item it);
        t_normal_res r;
        longint ax, ay, az, e1x, e1y, e1z, e2x, e2y, e2z;
        r = '{tag: '0, nx: '0, ny: '0, nz: '0, degen: 1'b0};
        case (it.kind)
            KIND_WRITE: begin
                pos_x_mem[it.vidx] = it.px;
                pos_y_mem[it.vidx] = it.py;
                pos_z_mem[it.vidx] = it.pz;
            end
            KIND_FACE: begin
                ax = pos_x_mem[it.ca]; ay = pos_y_mem[it.ca]; az = pos_z_mem[it.ca];
                e1x = pos_x_mem[it.cb] - ax; e1y = pos_y_mem[it.cb] - ay;
                e1z = pos_z_mem[it.cb] - az;
                e2x = pos_x_mem[it.cc] - ax; e2y = pos_y_mem[it.cc] - ay;
                e2z = pos_z_mem[it.cc] - az;
                unit_normal(e1y * e2z - e1z * e2y, e1z * e2x - e1x * e2z,
                            e1x * e2y - e1y * e2x, r.nx, r.ny, r.nz, r.degen);
                if (enable_q && !r.degen) begin
                    foreach (sum_x_mem[k]) begin
                        if (k == it.ca || k == it.cb || k == it.cc) begin
                            // a repeated corner gives a degenerate face, so each corner once
                            sum_x_mem[k] = sat_sum(sum_x_mem[k], r.nx);
                            sum_y_mem[k] = sat_sum(sum_y_mem[k], r.ny);
                            sum_z_mem[k] = sat_sum(sum_z_mem[k], r.nz);
                        end
                    end
                end
                r.tag = it.tag;
            end
            KIND_READ: begin
                unit_normal(sum_x_mem[it.vidx], sum_y_mem[it.vidx], sum_z_mem[it.vidx],
                            r.nx, r.ny, r.nz, r.degen);
                r.tag = TAG_W'(it.vidx);
            end
            default: begin
                foreach (sum_x_mem[k]) begin
                    sum_x_mem[k] = '0; sum_y_mem[k] = '0; sum_z_mem[k] = '0;
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic roll_idle(input int mode);
        if (mode == 1 || mode == 2) return $urandom_range(99) < 63;
        if (mode == 3) return $urandom_range(99) < 6;
        return 1'b0;
    endfunction

    // input driver
    always @(posedge i_clk) begin
        logic       busy;
        t_mesh_item it;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            busy = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                it.kind = t_kind'(i_kind); it.vidx = i_vertex_index;
                it.px = i_pos_x; it.py = i_pos_y; it.pz = i_pos_z;
                it.ca = i_corner_a; it.cb = i_corner_b; it.cc = i_corner_c;
                it.tag = i_face_tag;
                expected_normals.push_back(predict_normal(it));
                busy = 1'b0;
            end
            if (!busy) begin
                if (pending_items.size() > 0 && !hold_sender
                    && !(idle_mode == 1 || idle_mode == 3 ? roll_idle(idle_mode) : 1'b0)) begin
                    it = pending_items.pop_front();
                    i_kind <= it.kind; i_vertex_index <= it.vidx;
                    i_pos_x <= it.px; i_pos_y <= it.py; i_pos_z <= it.pz;
                    i_corner_a <= it.ca; i_corner_b <= it.cb; i_corner_c <= it.cc;
                    i_face_tag <= it.tag;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        t_normal_res e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_normals.size() == 0) begin
                    $display("%0t unexpected item tag %h", $time, o_item_tag);
                    errors++;
                end else begin
                    e = expected_normals.pop_front();
                    if (o_item_tag !== e.tag) begin
                        $display("%0t item_tag exp %h got %h", $time, e.tag, o_item_tag);
                        errors++;
                    end
                    if (o_norm_x !== e.nx) begin
                        $display("%0t norm_x exp %0d got %0d", $time, e.nx, o_norm_x);
                        errors++;
                    end
                    if (o_norm_y !== e.ny) begin
                        $display("%0t norm_y exp %0d got %0d", $time, e.ny, o_norm_y);
                        errors++;
                    end
                    if (o_norm_z !== e.nz) begin
                        $display("%0t norm_z exp %0d got %0d", $time, e.nz, o_norm_z);
                        errors++;
                    end
                    if (o_degenerate !== e.degen) begin
                        $display("%0t degenerate exp %b got %b", $time, e.degen, o_degenerate);
                        errors++;
                    end
                end
            end
            i_out_ready <= !(idle_mode == 2 || idle_mode == 3 ? roll_idle(idle_mode) : 1'b0);
        end
    end

    int written_list[$];

    task automatic add_item(input t_kind k, input int vidx, input int px, py, pz,
                            input int ca, cb, cc, input int tag);
        t_mesh_item it;
        it.kind = k; it.vidx = vidx[IDX_W-1:0];
        it.px = px[POS_W-1:0]; it.py = py[POS_W-1:0]; it.pz = pz[POS_W-1:0];
        it.ca = ca[IDX_W-1:0]; it.cb = cb[IDX_W-1:0]; it.cc = cc[IDX_W-1:0];
        it.tag = tag[TAG_W-1:0];
        if (k == KIND_WRITE) written_list.push_back(vidx);
        pending_items.push_back(it);
    endtask

    task automatic add_random_items(input int count);
        int r, ca, cb, cc;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 30) begin
                add_item(KIND_WRITE, $urandom_range(1023), $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, $urandom);
            end else if (r < 76) begin
                ca = written_list[$urandom_range(written_list.size() - 1)];
                cb = written_list[$urandom_range(written_list.size() - 1)];
                cc = written_list[$urandom_range(written_list.size() - 1)];
                if ($urandom_range(19) == 0) cb = ca;
                add_item(KIND_FACE, $urandom, $urandom, $urandom, $urandom,
                         ca, cb, cc, $urandom);
            end else if (r < 99) begin
                if ($urandom_range(1)) ca = $urandom_range(1023);
                else ca = written_list[$urandom_range(written_list.size() - 1)];
                add_item(KIND_READ, ca, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom);
            end else begin
                add_item(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || i_in_valid || expected_normals.size() != 0)
            @(posedge i_clk);
        // idle gap before the next phase
        repeat (1200) @(posedge i_clk);
    endtask

    task automatic write_enable(input logic v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        enable_q = v;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        foreach (sum_x_mem[k]) begin
            sum_x_mem[k] = '0; sum_y_mem[k] = '0; sum_z_mem[k] = '0;
            pos_x_mem[k] = '0; pos_y_mem[k] = '0; pos_z_mem[k] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_enable(1'b1);

        // directed items
        add_item(KIND_WRITE, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(KIND_WRITE, 1, 8388607, 0, 0, 0, 0, 0, 0);
        add_item(KIND_WRITE, 2, 0, 8388607, 0, 0, 0, 0, 0);
        add_item(KIND_WRITE, 3, -8388608, -8388608, 8388607, 0, 0, 0, 0);
        add_item(KIND_WRITE, 1023, 256, 512, -768, 1023, 1023, 1023, 65535);
        add_item(KIND_WRITE, 4, 100, 100, 100, 0, 0, 0, 0);
        add_item(KIND_WRITE, 5, 200, 200, 200, 0, 0, 0, 0);
        add_item(KIND_FACE, 0, 0, 0, 0, 0, 1, 2, 65535);
        add_item(KIND_FACE, 0, 0, 0, 0, 1, 2, 3, 0);
        add_item(KIND_FACE, 0, 0, 0, 0, 0, 0, 1, 16'h1234);
        add_item(KIND_FACE, 0, 0, 0, 0, 0, 4, 5, 16'h5a5a);
        add_item(KIND_FACE, 0, 0, 0, 0, 1023, 3, 2, 16'h8001);
        add_item(KIND_FACE, 0, 0, 0, 0, 3, 1023, 1, 16'h00ff);
        add_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(KIND_READ, 1, 0, 0, 0, 0, 0, 0, 0);
        add_item(KIND_READ, 3, 0, 0, 0, 0, 0, 0, 0);
        add_item(KIND_READ, 1023, 0, 0, 0, 0, 0, 0, 0);
        add_item(KIND_READ, 7, 0, 0, 0, 0, 0, 0, 0);
        add_item(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(KIND_READ, 1, 0, 0, 0, 0, 0, 0, 0);
        wait_drained();

        write_enable(1'b0);
        idle_mode = 0;
        add_random_items(200);
        wait_drained();

        write_enable(1'b1);
        idle_mode = 1;
        add_random_items(400);
        wait_drained();

        write_enable(1'b0);
        idle_mode = 2;
        add_random_items(300);
        wait_drained();

        write_enable(1'b1);
        idle_mode = 3;
        add_random_items(300);
        repeat (3000) @(posedge i_clk);
        hold_sender = 1'b1;
        while (i_in_valid || expected_normals.size() != 0) @(posedge i_clk);
        hold_sender = 1'b0;
        add_random_items(300);
        wait_drained();

        if (errors == 0 && expected_normals.size() == 0)
            $display("[mesh_face_vertex_normals] OK");
        else
            $display("[mesh_face_vertex_normals] ERROR");
        $finish;
    end

    initial begin
        #40000000;
        $display("[mesh_face_vertex_normals] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
